>>> hdl/segint_pkg.sv
// ----------------------------------------------------------------------------
// segint_pkg
// Shared types and constants for the segment intersection test core.
// ----------------------------------------------------------------------------
package segint_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   typedef enum logic [1:0] {
      OR_COL = 2'd0,
      OR_CW  = 2'd1,
      OR_CCW = 2'd2
   } orient_type;

endpackage

>>> hdl/segint_orient.sv
// ----------------------------------------------------------------------------
// segint_orient
// Three-stage orientation of point r against the directed line p-q:
// differences, exact products, signed compare.
// ----------------------------------------------------------------------------
module segint_orient #(
   parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic signed [COORD_WIDTH-1:0]  px,
   input  logic signed [COORD_WIDTH-1:0]  py,
   input  logic signed [COORD_WIDTH-1:0]  qx,
   input  logic signed [COORD_WIDTH-1:0]  qy,
   input  logic signed [COORD_WIDTH-1:0]  rx,
   input  logic signed [COORD_WIDTH-1:0]  ry,
   output segint_pkg::orient_type         orient
);
   import segint_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] dqy_ff, drx_ff, dry_ff, dqx_ff;
   logic signed [DW-1:0] dqy_in, drx_in, dry_in, dqx_in;
   logic signed [PW-1:0] s1_ff, s2_ff, s1_in, s2_in;
   orient_type           orient_ff, orient_in;

   // stage 1: differences, one bit wider than the coordinates
   always_comb begin
      dqy_in = DW'(qy) - DW'(py);
      drx_in = DW'(rx) - DW'(qx);
      dry_in = DW'(ry) - DW'(qy);
      dqx_in = DW'(qx) - DW'(px);
   end

   // stage 2: exact products
   always_comb begin
      s1_in = PW'(dqy_ff) * PW'(drx_ff);
      s2_in = PW'(dry_ff) * PW'(dqx_ff);
   end

   // stage 3: compare
   always_comb begin
      if (s1_ff == s2_ff) begin
         orient_in = OR_COL;
      end else if (s1_ff > s2_ff) begin
         orient_in = OR_CW;
      end else begin
         orient_in = OR_CCW;
      end
   end

   always_ff @(posedge clock) begin
      dqy_ff    <= dqy_in;
      drx_ff    <= drx_in;
      dry_ff    <= dry_in;
      dqx_ff    <= dqx_in;
      s1_ff     <= s1_in;
      s2_ff     <= s2_in;
      orient_ff <= orient_in;
   end

   assign orient = orient_ff;

endmodule

>>> hdl/segment_intersection_test_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Segment pair intersection test by four exact orientations, with an
// optional colinear touch rule.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Stages: differences and box compares, products, compares, hit combine.
// Reset (synchronous, active high) clears the valid bits, the result strobe and colinear_mode.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module segment_intersection_test_core #(
   parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [COORD_WIDTH-1:0]  req_ax0,
   input  logic signed [COORD_WIDTH-1:0]  req_ay0,
   input  logic signed [COORD_WIDTH-1:0]  req_ax1,
   input  logic signed [COORD_WIDTH-1:0]  req_ay1,
   input  logic signed [COORD_WIDTH-1:0]  req_bx0,
   input  logic signed [COORD_WIDTH-1:0]  req_by0,
   input  logic signed [COORD_WIDTH-1:0]  req_bx1,
   input  logic signed [COORD_WIDTH-1:0]  req_by1,
   input  logic                           csr_we,
   input  logic                           csr_wdata,
   output logic                           rsp_strobe,
   output logic                           rsp_hit
);
   import segint_pkg::*;

   logic       mode_ff, mode_in;
   logic [2:0] vld_ff, vld_in;
   logic       strobe_ff, strobe_in;
   logic       hit_ff, hit_in;

   // box bits: b0 in A, b1 in A, a0 in B, a1 in B
   logic [3:0] box1_ff, box2_ff, box3_ff, box_in;
   orient_type o1, o2, o3, o4;

   function automatic logic between(input logic signed [COORD_WIDTH-1:0] t,
                                    input logic signed [COORD_WIDTH-1:0] e0,
                                    input logic signed [COORD_WIDTH-1:0] e1);
      between = (t >= e0 && t <= e1) || (t >= e1 && t <= e0);
   endfunction

   assign busy = 1'b0;

   always_comb begin
      mode_in = csr_we ? csr_wdata : mode_ff;
      vld_in  = {vld_ff[1:0], start & ~busy};
      box_in[0] = between(req_bx0, req_ax0, req_ax1) && between(req_by0, req_ay0, req_ay1);
      box_in[1] = between(req_bx1, req_ax0, req_ax1) && between(req_by1, req_ay0, req_ay1);
      box_in[2] = between(req_ax0, req_bx0, req_bx1) && between(req_ay0, req_by0, req_by1);
      box_in[3] = between(req_ax1, req_bx0, req_bx1) && between(req_ay1, req_by0, req_by1);
   end

   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_o1 (
      .clock(clock), .px(req_ax0), .py(req_ay0), .qx(req_ax1), .qy(req_ay1),
      .rx(req_bx0), .ry(req_by0), .orient(o1));
   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_o2 (
      .clock(clock), .px(req_ax0), .py(req_ay0), .qx(req_ax1), .qy(req_ay1),
      .rx(req_bx1), .ry(req_by1), .orient(o2));
   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_o3 (
      .clock(clock), .px(req_bx0), .py(req_by0), .qx(req_bx1), .qy(req_by1),
      .rx(req_ax0), .ry(req_ay0), .orient(o3));
   segint_orient #(.COORD_WIDTH(COORD_WIDTH)) u_o4 (
      .clock(clock), .px(req_bx0), .py(req_by0), .qx(req_bx1), .qy(req_by1),
      .rx(req_ax1), .ry(req_ay1), .orient(o4));

   // final stage: proper crossing, else colinear touch when enabled
   always_comb begin
      strobe_in = vld_ff[2];
      if (o1 != o2 && o3 != o4) begin
         hit_in = 1'b1;
      end else begin
         hit_in = mode_ff && ((o1 == OR_COL && box3_ff[0]) ||
                              (o2 == OR_COL && box3_ff[1]) ||
                              (o3 == OR_COL && box3_ff[2]) ||
                              (o4 == OR_COL && box3_ff[3]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         vld_ff    <= vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      box1_ff <= box_in;
      box2_ff <= box1_ff;
      box3_ff <= box2_ff;
      hit_ff  <= hit_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_hit    = hit_ff;

   // every accepted word produces a result strobe
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("accepted word did not produce a result");

   // no result without a word in the last valid stage just before it
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(vld_ff[2], 1))
      else $error("result strobe without a word in flight");

   // proper crossing always reports a hit
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && o1 != o2 && o3 != o4) |=> rsp_hit)
      else $error("crossing segments not reported");

   // with colinear mode off, a hit needs a proper crossing
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !mode_ff && !(o1 != o2 && o3 != o4)) |=> !rsp_hit)
      else $error("hit reported without crossing");

endmodule
